// ===== design/pcp_pkg.sv =====
// shared types and constants for the planar contact penalty block
// used by pcp_ctrl, pcp_datapath and planar_contact_penalty_2d; no dependencies
package pcp_pkg;

    localparam int MAX_FACES_DEF = 64;

    // command codes of an input transaction
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic CFG_STIFFNESS  = 1'b0;
    localparam logic CFG_FACE_COUNT = 1'b1;

    localparam logic [31:0] STIFF_RESET = 32'h0001_0000;

    // multiply steps of the contact product sequence
    typedef enum logic [3:0] {
        MUL_CD,
        MUL_EN,
        MUL_FX,
        MUL_FY,
        MUL_CX,
        MUL_XX,
        MUL_XY,
        MUL_CY,
        MUL_YY
    } mul_op_t;

    // one stored boundary segment
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [17:0] nx;
        logic [17:0] ny;
        logic [31:0] xl;
        logic [31:0] xh;
        logic [31:0] yl;
        logic [31:0] yh;
    } seg_t;

    // controller to datapath
    typedef struct packed {
        logic    load_we;
        logic    query_latch;
        logic    scan_issue;
        logic    read_best;
        logic    bound_a;
        logic    bound_b;
        logic    mul_en;
        logic    mul_first;
        logic [1:0] mul_digit;
        mul_op_t mul_op;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       found;
        logic       contact;
        logic [6:0] face_count;
    } status_t;

endpackage

// ===== design/planar_contact_penalty_2d.sv =====
// top level of the planar contact penalty block
// depends on pcp_pkg, pcp_ctrl and pcp_datapath
//
// channel   handshake            payload
// input     start, busy          command, face_slot, vertex_*, normal_*, query_*
// result    done (one cycle)     energy, force_*, stiff_*, penetration,
//                                nearest_face, in_contact
// config    cfg_we               cfg_addr, cfg_wdata
//
// a load is written in the accept cycle and gives no result; busy stays low
// a query reads one segment per cycle, up to face_count, through the single read
// port of the table, then runs the box test and a product sequence on one 18x36
// multiplier (skipped when there is no contact)
// reset clears control and configuration; the table is undefined until loaded
// the result receiver cannot stall; done marks a result for one cycle
module planar_contact_penalty_2d #(
    parameter int MAX_FACES = pcp_pkg::MAX_FACES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  logic                command,
    input  logic [5:0]          face_slot,
    input  logic signed [31:0]  vertex_a_x,
    input  logic signed [31:0]  vertex_a_y,
    input  logic signed [31:0]  vertex_b_x,
    input  logic signed [31:0]  vertex_b_y,
    input  logic signed [17:0]  normal_x,
    input  logic signed [17:0]  normal_y,
    input  logic signed [31:0]  query_x,
    input  logic signed [31:0]  query_y,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [31:0]         cfg_wdata,
    output logic [62:0]         energy,
    output logic signed [47:0]  force_x,
    output logic signed [47:0]  force_y,
    output logic signed [47:0]  stiff_xx,
    output logic signed [47:0]  stiff_xy,
    output logic signed [47:0]  stiff_yy,
    output logic signed [31:0]  penetration,
    output logic [5:0]          nearest_face,
    output logic                in_contact
);

    localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW = $clog2(MAX_FACES + 1);

    pcp_pkg::cmd_t     cmd;
    pcp_pkg::status_t  status;
    logic [AW-1:0]     scan_addr;

    // sequencer
    pcp_ctrl #(
        .MAX_FACES (MAX_FACES),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .status    (status),
        .cmd       (cmd),
        .scan_addr (scan_addr),
        .busy      (busy),
        .done      (done)
    );

    // table and arithmetic
    pcp_datapath #(
        .MAX_FACES (MAX_FACES),
        .AW        (AW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .scan_addr    (scan_addr),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .face_slot    (face_slot),
        .vertex_a_x   (vertex_a_x),
        .vertex_a_y   (vertex_a_y),
        .vertex_b_x   (vertex_b_x),
        .vertex_b_y   (vertex_b_y),
        .normal_x     (normal_x),
        .normal_y     (normal_y),
        .query_x      (query_x),
        .query_y      (query_y),
        .energy       (energy),
        .force_x      (force_x),
        .force_y      (force_y),
        .stiff_xx     (stiff_xx),
        .stiff_xy     (stiff_xy),
        .stiff_yy     (stiff_yy),
        .penetration  (penetration),
        .nearest_face (nearest_face),
        .in_contact   (in_contact)
    );

endmodule

// ===== design/pcp_ctrl.sv =====
// sequencing state machine of the planar contact penalty block
// depends on pcp_pkg; drives pcp_datapath through cmd_t and reads status_t
module pcp_ctrl #(
    parameter int MAX_FACES = pcp_pkg::MAX_FACES_DEF,
    parameter int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1,
    parameter int CW = $clog2(MAX_FACES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             command,
    input  pcp_pkg::status_t status,
    output pcp_pkg::cmd_t    cmd,
    output logic [AW-1:0]    scan_addr,
    output logic             busy,
    output logic             done
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_LOOK,
        ST_BND1,
        ST_BND2,
        ST_BND3,
        ST_MUL,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [1:0]          cnt_reg, cnt_next;
    pcp_pkg::mul_op_t    op_reg, op_next;
    logic                busy_reg, done_reg;
    logic [CW-1:0]       count;

    // number of segments to scan, limited to the table depth
    assign count = (int'(status.face_count) > MAX_FACES) ? CW'(MAX_FACES)
                                                          : CW'(status.face_count);
    assign scan_addr = idx_reg[AW-1:0];
    assign busy = busy_reg;
    assign done = done_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        op_next = op_reg;
        cmd = '0;
        cmd.mul_op = op_reg;
        cmd.mul_digit = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (command == pcp_pkg::CMD_QUERY)
                    begin
                        cmd.query_latch = 1'b1;
                        idx_next = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load_we = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == count)
                begin
                    cnt_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.scan_issue = 1'b1;
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = status.found ? ST_LOOK : ST_DONE;
                end
            end
            ST_LOOK:
            begin
                cmd.read_best = 1'b1;
                state_next = ST_BND1;
            end
            ST_BND1:
            begin
                cmd.bound_a = 1'b1;
                state_next = ST_BND2;
            end
            ST_BND2:
            begin
                cmd.bound_b = 1'b1;
                state_next = ST_BND3;
            end
            ST_BND3:
            begin
                cnt_next = '0;
                op_next = pcp_pkg::MUL_CD;
                state_next = status.contact ? ST_MUL : ST_DONE;
            end
            ST_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_first = (cnt_reg == 2'd0);
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    if (op_reg == pcp_pkg::MUL_YY)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        op_next = pcp_pkg::mul_op_t'(op_reg + 4'd1);
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg <= '0;
            cnt_reg <= '0;
            op_reg <= pcp_pkg::MUL_CD;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            op_reg <= op_next;
            busy_reg <= (state_next != ST_IDLE);
            done_reg <= (state_next == ST_DONE);
        end
    end

endmodule

// ===== design/pcp_datapath.sv =====
// segment table, nearest scan pipeline, box test and product unit
// depends on pcp_pkg; commanded by pcp_ctrl
module pcp_datapath #(
    parameter int MAX_FACES = pcp_pkg::MAX_FACES_DEF,
    parameter int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pcp_pkg::cmd_t        cmd,
    input  logic [AW-1:0]        scan_addr,
    output pcp_pkg::status_t     status,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [31:0]          cfg_wdata,
    input  logic [5:0]           face_slot,
    input  logic signed [31:0]   vertex_a_x,
    input  logic signed [31:0]   vertex_a_y,
    input  logic signed [31:0]   vertex_b_x,
    input  logic signed [31:0]   vertex_b_y,
    input  logic signed [17:0]   normal_x,
    input  logic signed [17:0]   normal_y,
    input  logic signed [31:0]   query_x,
    input  logic signed [31:0]   query_y,
    output logic [62:0]          energy,
    output logic signed [47:0]   force_x,
    output logic signed [47:0]   force_y,
    output logic signed [47:0]   stiff_xx,
    output logic signed [47:0]   stiff_xy,
    output logic signed [47:0]   stiff_yy,
    output logic signed [31:0]   penetration,
    output logic [5:0]           nearest_face,
    output logic                 in_contact
);

    pcp_pkg::seg_t       mem [MAX_FACES];
    pcp_pkg::seg_t       wr_entry;
    pcp_pkg::seg_t       rd_reg;
    logic [AW-1:0]       rd_addr;

    logic [31:0]         stiff_reg;
    logic [6:0]          fcount_reg;
    logic signed [31:0]  qx_reg, qy_reg;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [AW-1:0]       s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic signed [32:0]  s2_dx_reg, s2_dy_reg;
    logic signed [17:0]  s2_nx_reg, s2_ny_reg;
    logic signed [50:0]  s3_px_reg, s3_py_reg;
    logic signed [51:0]  d_sum;
    logic [51:0]         d_mag;

    logic                found_reg;
    logic [51:0]         best_m_reg;
    logic signed [51:0]  best_d_reg;
    logic [AW-1:0]       best_i_reg;

    logic signed [35:0]  dq;
    logic signed [17:0]  e_nx, e_ny;
    logic signed [53:0]  prodx_reg, prody_reg;
    logic [35:0]         md_reg;
    logic [17:0]         mx_reg, my_reg;
    logic                neg_fx_reg, neg_fy_reg, neg_xy_reg;
    logic signed [38:0]  xt, yt;
    logic                in_box;
    logic                contact_reg;

    logic [107:0]        acc_reg, acc_next, pp;
    logic [71:0]         op_a;
    logic [35:0]         op_b;
    logic [17:0]         a_digit;
    logic [67:0]         t_reg;
    logic [49:0]         u_reg;
    logic [107:0]        sh17, sh32;

    // clamp a shifted magnitude to 48 bits and apply the sign
    function automatic logic [47:0] sat48(input logic [107:0] v, input logic neg);
        logic [47:0] m;
        if (neg)
        begin
            if ((|v[107:48]) || (v[47:0] > 48'h8000_0000_0000))
                m = 48'h8000_0000_0000;
            else
                m = v[47:0];
            sat48 = 48'd0 - m;
        end
        else
        begin
            if (|v[107:47])
                m = 48'h7FFF_FFFF_FFFF;
            else
                m = v[47:0];
            sat48 = m;
        end
    endfunction

    assign status.found = found_reg;
    assign status.contact = contact_reg;
    assign status.face_count = fcount_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiff_reg <= pcp_pkg::STIFF_RESET;
            fcount_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == pcp_pkg::CFG_STIFFNESS)
                stiff_reg <= cfg_wdata;
            else
                fcount_reg <= cfg_wdata[6:0];
        end
    end

    // segment entry with its bounding box
    always_comb
    begin
        wr_entry.px = vertex_a_x;
        wr_entry.py = vertex_a_y;
        wr_entry.nx = normal_x;
        wr_entry.ny = normal_y;
        wr_entry.xl = (vertex_a_x < vertex_b_x) ? vertex_a_x : vertex_b_x;
        wr_entry.xh = (vertex_a_x < vertex_b_x) ? vertex_b_x : vertex_a_x;
        wr_entry.yl = (vertex_a_y < vertex_b_y) ? vertex_a_y : vertex_b_y;
        wr_entry.yh = (vertex_a_y < vertex_b_y) ? vertex_b_y : vertex_a_y;
    end

    assign rd_addr = cmd.read_best ? best_i_reg : scan_addr;

    // segment table, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (int'(face_slot) < MAX_FACES))
            mem[AW'(face_slot)] <= wr_entry;
        if (cmd.scan_issue || cmd.read_best)
            rd_reg <= mem[rd_addr];
    end

    // scan pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            found_reg <= 1'b0;
            contact_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.scan_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.query_latch)
            begin
                found_reg <= 1'b0;
                contact_reg <= 1'b0;
            end
            else
            begin
                if (s3_valid_reg && (!found_reg || (d_mag < best_m_reg)))
                    found_reg <= 1'b1;
                if (cmd.bound_b)
                    contact_reg <= best_d_reg[51] && in_box;
            end
        end
    end

    assign d_sum = s3_px_reg + s3_py_reg;
    assign d_mag = d_sum[51] ? 52'(-d_sum) : 52'(d_sum);

    // scan stages: offsets, products, nearest pick
    always_ff @(posedge clk)
    begin
        if (cmd.query_latch)
        begin
            qx_reg <= query_x;
            qy_reg <= query_y;
        end
        s1_idx_reg <= scan_addr;
        s2_idx_reg <= s1_idx_reg;
        s3_idx_reg <= s2_idx_reg;
        s2_dx_reg <= 33'(qx_reg) - 33'($signed(rd_reg.px));
        s2_dy_reg <= 33'(qy_reg) - 33'($signed(rd_reg.py));
        s2_nx_reg <= $signed(rd_reg.nx);
        s2_ny_reg <= $signed(rd_reg.ny);
        s3_px_reg <= s2_dx_reg * s2_nx_reg;
        s3_py_reg <= s2_dy_reg * s2_ny_reg;
        if (s3_valid_reg && (!found_reg || (d_mag < best_m_reg)))
        begin
            best_m_reg <= d_mag;
            best_d_reg <= d_sum;
            best_i_reg <= s3_idx_reg;
        end
    end

    assign dq = best_d_reg[51:16];
    assign e_nx = $signed(rd_reg.nx);
    assign e_ny = $signed(rd_reg.ny);
    assign xt = 39'(qx_reg) - 39'($signed(prodx_reg[53:16]));
    assign yt = 39'(qy_reg) - 39'($signed(prody_reg[53:16]));
    assign in_box = (xt <= 39'($signed(rd_reg.xh))) && (xt >= 39'($signed(rd_reg.xl)))
                 && (yt <= 39'($signed(rd_reg.yh))) && (yt >= 39'($signed(rd_reg.yl)));

    // product unit operands
    always_comb
    begin
        unique case (cmd.mul_op)
            pcp_pkg::MUL_CD: begin op_a = 72'(stiff_reg); op_b = md_reg; end
            pcp_pkg::MUL_EN: begin op_a = 72'(t_reg);     op_b = md_reg; end
            pcp_pkg::MUL_FX: begin op_a = 72'(t_reg);     op_b = 36'(mx_reg); end
            pcp_pkg::MUL_FY: begin op_a = 72'(t_reg);     op_b = 36'(my_reg); end
            pcp_pkg::MUL_CX: begin op_a = 72'(stiff_reg); op_b = 36'(mx_reg); end
            pcp_pkg::MUL_XX: begin op_a = 72'(u_reg);     op_b = 36'(mx_reg); end
            pcp_pkg::MUL_XY: begin op_a = 72'(u_reg);     op_b = 36'(my_reg); end
            pcp_pkg::MUL_CY: begin op_a = 72'(stiff_reg); op_b = 36'(my_reg); end
            pcp_pkg::MUL_YY: begin op_a = 72'(u_reg);     op_b = 36'(my_reg); end
            default:         begin op_a = '0;             op_b = '0; end
        endcase
    end

    // one 18-bit digit of operand a per cycle
    always_comb
    begin
        unique case (cmd.mul_digit)
            2'd0: a_digit = op_a[17:0];
            2'd1: a_digit = op_a[35:18];
            2'd2: a_digit = op_a[53:36];
            2'd3: a_digit = op_a[71:54];
            default: a_digit = '0;
        endcase
        pp = 108'(54'(a_digit) * 54'(op_b));
        unique case (cmd.mul_digit)
            2'd0: pp = pp;
            2'd1: pp = pp << 18;
            2'd2: pp = pp << 36;
            2'd3: pp = pp << 54;
            default: pp = '0;
        endcase
        acc_next = (cmd.mul_first ? 108'd0 : acc_reg) + pp;
        sh17 = acc_next >> 17;
        sh32 = acc_next >> 32;
    end

    // bound check and products into the result registers
    always_ff @(posedge clk)
    begin
        if (cmd.query_latch)
        begin
            energy <= '0;
            force_x <= '0;
            force_y <= '0;
            stiff_xx <= '0;
            stiff_xy <= '0;
            stiff_yy <= '0;
            penetration <= '0;
            nearest_face <= '0;
            in_contact <= 1'b0;
        end
        if (cmd.bound_a)
        begin
            prodx_reg <= dq * e_nx;
            prody_reg <= dq * e_ny;
            md_reg <= dq[35] ? 36'(-dq) : 36'(dq);
            mx_reg <= e_nx[17] ? 18'(-e_nx) : 18'(e_nx);
            my_reg <= e_ny[17] ? 18'(-e_ny) : 18'(e_ny);
            neg_fx_reg <= !e_nx[17] && (|e_nx);
            neg_fy_reg <= !e_ny[17] && (|e_ny);
            neg_xy_reg <= (e_nx[17] != e_ny[17]) && (|e_nx) && (|e_ny);
            if (dq[35:31] == 5'b00000 || dq[35:31] == 5'b11111)
                penetration <= dq[31:0];
            else
                penetration <= dq[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            nearest_face <= 6'(best_i_reg);
        end
        if (cmd.bound_b)
            in_contact <= best_d_reg[51] && in_box;
        if (cmd.mul_en)
        begin
            acc_reg <= acc_next;
            if (cmd.mul_digit == 2'd3)
            begin
                unique case (cmd.mul_op)
                    pcp_pkg::MUL_CD: t_reg <= acc_next[67:0];
                    pcp_pkg::MUL_EN: energy <= (|sh17[107:63]) ? {63{1'b1}} : sh17[62:0];
                    pcp_pkg::MUL_FX: force_x <= sat48(sh32, neg_fx_reg);
                    pcp_pkg::MUL_FY: force_y <= sat48(sh32, neg_fy_reg);
                    pcp_pkg::MUL_CX: u_reg <= acc_next[49:0];
                    pcp_pkg::MUL_XX: stiff_xx <= sat48(sh32, 1'b0);
                    pcp_pkg::MUL_XY: stiff_xy <= sat48(sh32, neg_xy_reg);
                    pcp_pkg::MUL_CY: u_reg <= acc_next[49:0];
                    pcp_pkg::MUL_YY: stiff_yy <= sat48(sh32, 1'b0);
                    default: ;
                endcase
            end
        end
    end

endmodule
